@@ design/ste_pkg.sv @@
// ----------------------------------------------------------------------------
// ste_pkg
// Shared types, tap coefficients and arithmetic constants of the skin
// temperature FIR estimator.
// ----------------------------------------------------------------------------
package ste_pkg;

  // filter geometry
  localparam int TAPS        = 20;
  localparam int TAP_IDX_W   = $clog2(TAPS);
  localparam int TAP_GROUPS  = 4;
  localparam int GROUP_SIZE  = TAPS / TAP_GROUPS;

  // field widths
  localparam int TEMP_W      = 18;
  localparam int BATT_W      = 12;
  localparam int SKIN_W      = 21;

  // accumulator widths (die/ext taps reach 81 and 22 in absolute sum,
  // battery taps 193)
  localparam int HIST_SUM_W  = 26;
  localparam int BATT_SUM_W  = 21;

  // divide by 100 through a reciprocal, exact for magnitudes below 2^24
  localparam int MAG_W       = 24;
  localparam int RECIP_W     = 25;
  localparam int DIV_SHIFT   = 31;
  localparam int PROD_W      = MAG_W + RECIP_W;
  localparam int QUOT_W      = 18;
  localparam logic [RECIP_W-1:0] DIV_RECIP = 25'd21474837;

  // final sum and clamp
  localparam int TOTAL_W     = 23;
  localparam logic signed [TOTAL_W-1:0] SKIN_OFFSET = 23'sd9793;
  localparam logic signed [TOTAL_W-1:0] SKIN_MIN    = -23'sd1048576;
  localparam logic signed [TOTAL_W-1:0] SKIN_MAX    = 23'sd1048575;

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic signed [BATT_W-1:0] batt_t;
  typedef logic signed [SKIN_W-1:0] skin_t;
  typedef logic signed [7:0]        coef_t;
  typedef logic [TAP_IDX_W-1:0]     tap_idx_t;

  typedef enum logic [1:0] {
    CH_DIE,
    CH_EXT,
    CH_BATT
  } chan_e;

  // stage advance strobes, lane stages first
  typedef struct packed {
    logic lane1;
    logic lane2;
    logic pair;
    logic mag;
    logic mul;
    logic quot;
    logic out;
  } adv_t;

  localparam coef_t DIE_COEF [TAPS] = '{
    -8'sd11, -8'sd7, -8'sd5, -8'sd3, -8'sd3, -8'sd2, -8'sd1, 8'sd0, 8'sd0, 8'sd0,
    8'sd1, 8'sd1, 8'sd1, 8'sd2, 8'sd2, 8'sd3, 8'sd4, 8'sd6, 8'sd11, 8'sd18
  };

  localparam coef_t EXT_COEF [TAPS] = '{
    8'sd2, 8'sd1, 8'sd1, 8'sd1, 8'sd1, 8'sd1, 8'sd1, 8'sd1, 8'sd1, 8'sd1,
    8'sd1, 8'sd0, 8'sd1, 8'sd1, 8'sd0, 8'sd0, 8'sd0, 8'sd0, -8'sd1, -8'sd7
  };

  localparam coef_t BATT_COEF [TAPS] = '{
    -8'sd38, -8'sd11, -8'sd3, -8'sd2, -8'sd2, -8'sd1, -8'sd1, -8'sd1, 8'sd0, 8'sd11,
    -8'sd13, 8'sd6, 8'sd7, 8'sd5, 8'sd6, 8'sd6, 8'sd6, 8'sd6, 8'sd13, 8'sd55
  };

  // tap k weights the sample written k items earlier
  function automatic coef_t coef(input chan_e ch, input tap_idx_t k);
    coef_t c;
    unique case (ch)
      CH_DIE:  c = DIE_COEF[k];
      CH_EXT:  c = EXT_COEF[k];
      CH_BATT: c = BATT_COEF[k];
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

endpackage

@@ design/ste_in_if.sv @@
// ----------------------------------------------------------------------------
// ste_in_if
// Sample channel: three temperature samples and the preload flag.
// ----------------------------------------------------------------------------
interface ste_in_if;
  import ste_pkg::*;

  logic  valid;
  logic  ready;
  temp_t die_temp;
  temp_t ext_temp;
  batt_t batt_temp;
  logic  preload;

  modport source (output valid, die_temp, ext_temp, batt_temp, preload, input ready);
  modport sink   (input valid, die_temp, ext_temp, batt_temp, preload, output ready);
endinterface

@@ design/ste_out_if.sv @@
// ----------------------------------------------------------------------------
// ste_out_if
// Result channel: estimated skin temperature.
// ----------------------------------------------------------------------------
interface ste_out_if;
  import ste_pkg::*;

  logic  valid;
  logic  ready;
  skin_t skin_temp;

  modport source (output valid, skin_temp, input ready);
  modport sink   (input valid, skin_temp, output ready);
endinterface

@@ design/skin_temp_fir_estimator_top.sv @@
// ----------------------------------------------------------------------------
// skin_temp_fir_estimator_top
// Skin temperature estimate from three FIR-filtered temperature channels.
//
//   channel     role    payload                                  per item
//   sample_in   sink    die_temp, ext_temp, batt_temp, preload   3 samples
//   result_out  source  skin_temp                                0 or 1 result
//
// One item per cycle sustained while result_out is ready; each item passes
// through two lane stages (grouped products, group sum) and five merge stages
// (pair add, magnitude, reciprocal multiply, quotient, offset and clamp).
// Histories update at acceptance, so a preload item takes an input slot and
// leaves no result. Stages only hold while every later stage is full, so
// bubbles close up under a stalled output. rst clears histories and valids,
// and the input is not ready while rst is high.
// ----------------------------------------------------------------------------
module skin_temp_fir_estimator_top (
  input  logic      clk,
  input  logic      rst,
  ste_in_if.sink    sample_in,
  ste_out_if.source result_out
);
  import ste_pkg::*;

  // stage valids: lane1, lane2, pair, mag, mul, quot, out
  logic [6:0] stage_valid;
  logic [6:0] stage_valid_next;
  adv_t       adv;
  logic       accept;
  logic       shift;
  logic       fill;

  logic signed [HIST_SUM_W-1:0] die_sum;
  logic signed [HIST_SUM_W-1:0] ext_sum;
  logic signed [BATT_SUM_W-1:0] batt_sum;

  // advance chain: a stage loads when empty or when its successor loads
  always_comb begin
    adv.out   = !stage_valid[0] || result_out.ready;
    adv.quot  = !stage_valid[1] || adv.out;
    adv.mul   = !stage_valid[2] || adv.quot;
    adv.mag   = !stage_valid[3] || adv.mul;
    adv.pair  = !stage_valid[4] || adv.mag;
    adv.lane2 = !stage_valid[5] || adv.pair;
    adv.lane1 = !stage_valid[6] || adv.lane2;
  end

  assign sample_in.ready = adv.lane1 && !rst;
  assign accept          = sample_in.valid && sample_in.ready;
  assign shift           = accept && !sample_in.preload;
  assign fill            = accept && sample_in.preload;

  // valid bits follow the stage loads
  always_comb begin
    stage_valid_next[6] = adv.lane1 ? shift          : stage_valid[6];
    stage_valid_next[5] = adv.lane2 ? stage_valid[6] : stage_valid[5];
    stage_valid_next[4] = adv.pair  ? stage_valid[5] : stage_valid[4];
    stage_valid_next[3] = adv.mag   ? stage_valid[4] : stage_valid[3];
    stage_valid_next[2] = adv.mul   ? stage_valid[3] : stage_valid[2];
    stage_valid_next[1] = adv.quot  ? stage_valid[2] : stage_valid[1];
    stage_valid_next[0] = adv.out   ? stage_valid[1] : stage_valid[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      stage_valid <= stage_valid_next;
    end
  end

  // three filter lanes
  ste_lane #(
    .SAMPLE_W (TEMP_W),
    .SUM_W    (HIST_SUM_W),
    .CHAN     (CH_DIE)
  ) u_die_lane (
    .clk    (clk),
    .rst    (rst),
    .shift  (shift),
    .fill   (fill),
    .sample (sample_in.die_temp),
    .adv1   (adv.lane1),
    .adv2   (adv.lane2),
    .sum    (die_sum)
  );

  ste_lane #(
    .SAMPLE_W (TEMP_W),
    .SUM_W    (HIST_SUM_W),
    .CHAN     (CH_EXT)
  ) u_ext_lane (
    .clk    (clk),
    .rst    (rst),
    .shift  (shift),
    .fill   (fill),
    .sample (sample_in.ext_temp),
    .adv1   (adv.lane1),
    .adv2   (adv.lane2),
    .sum    (ext_sum)
  );

  ste_lane #(
    .SAMPLE_W (BATT_W),
    .SUM_W    (BATT_SUM_W),
    .CHAN     (CH_BATT)
  ) u_batt_lane (
    .clk    (clk),
    .rst    (rst),
    .shift  (shift),
    .fill   (fill),
    .sample (sample_in.batt_temp),
    .adv1   (adv.lane1),
    .adv2   (adv.lane2),
    .sum    (batt_sum)
  );

  // combine lanes into the estimate
  ste_merge u_merge (
    .clk       (clk),
    .adv       (adv),
    .die_sum   (die_sum),
    .ext_sum   (ext_sum),
    .batt_sum  (batt_sum),
    .skin_temp (result_out.skin_temp)
  );

  assign result_out.valid = stage_valid[0];

endmodule

@@ design/ste_lane.sv @@
// ----------------------------------------------------------------------------
// ste_lane
// One FIR lane: sample history as a shift line with the newest sample at
// tap 0, grouped partial products, then a registered group sum.
// ----------------------------------------------------------------------------
module ste_lane #(
  parameter int            SAMPLE_W = 18,
  parameter int            SUM_W    = 26,
  parameter ste_pkg::chan_e CHAN    = ste_pkg::CH_DIE
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       shift,
  input  logic                       fill,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       adv1,
  input  logic                       adv2,
  output logic signed [SUM_W-1:0]    sum
);
  import ste_pkg::*;

  logic signed [SAMPLE_W-1:0] hist      [TAPS];
  logic signed [SAMPLE_W-1:0] hist_next [TAPS];
  logic signed [SAMPLE_W-1:0] win       [TAPS];
  logic signed [SUM_W-1:0]    part      [TAP_GROUPS];
  logic signed [SUM_W-1:0]    part_next [TAP_GROUPS];
  logic signed [SUM_W-1:0]    sum_next;

  // window as seen by a normal item: its own sample at tap 0
  always_comb begin
    win[0] = sample;
    for (int k = 1; k < TAPS; k++) begin
      win[k] = hist[k-1];
    end
  end

  // history update: preload fills every entry, normal item shifts in
  always_comb begin
    for (int k = 0; k < TAPS; k++) begin
      if (fill) begin
        hist_next[k] = sample;
      end else if (shift) begin
        hist_next[k] = win[k];
      end else begin
        hist_next[k] = hist[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TAPS; k++) begin
        hist[k] <= '0;
      end
    end else begin
      hist <= hist_next;
    end
  end

  // constant-coefficient products, summed per group
  always_comb begin
    logic signed [SUM_W-1:0] acc;
    for (int g = 0; g < TAP_GROUPS; g++) begin
      acc = '0;
      for (int i = 0; i < GROUP_SIZE; i++) begin
        acc = acc + SUM_W'(win[g*GROUP_SIZE+i])
                    * SUM_W'(coef(CHAN, TAP_IDX_W'(g*GROUP_SIZE+i)));
      end
      part_next[g] = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      part <= part_next;
    end
  end

  // group sum
  always_comb begin
    sum_next = '0;
    for (int g = 0; g < TAP_GROUPS; g++) begin
      sum_next = sum_next + part[g];
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      sum <= sum_next;
    end
  end

endmodule

@@ design/ste_merge.sv @@
// ----------------------------------------------------------------------------
// ste_merge
// Combines the lane sums: (die + ext) / 100 truncated toward zero, plus the
// battery sum and the offset, clamped to the output range.
// ----------------------------------------------------------------------------
module ste_merge (
  input  logic                                   clk,
  input  ste_pkg::adv_t                          adv,
  input  logic signed [ste_pkg::HIST_SUM_W-1:0]  die_sum,
  input  logic signed [ste_pkg::HIST_SUM_W-1:0]  ext_sum,
  input  logic signed [ste_pkg::BATT_SUM_W-1:0]  batt_sum,
  output ste_pkg::skin_t                         skin_temp
);
  import ste_pkg::*;

  logic signed [HIST_SUM_W-1:0] pair;
  logic signed [BATT_SUM_W-1:0] batt_pair;
  logic                         neg_mag;
  logic [MAG_W-1:0]             mag;
  logic signed [BATT_SUM_W-1:0] batt_mag;
  logic                         neg_mul;
  logic [PROD_W-1:0]            prod;
  logic signed [BATT_SUM_W-1:0] batt_mul;
  logic signed [QUOT_W:0]       quot;
  logic signed [BATT_SUM_W-1:0] batt_quot;
  logic [QUOT_W-1:0]            quot_mag;
  logic signed [HIST_SUM_W-1:0] pair_abs;
  logic signed [TOTAL_W-1:0]    total;

  // die plus ext
  always_ff @(posedge clk) begin
    if (adv.pair) begin
      pair      <= die_sum + ext_sum;
      batt_pair <= batt_sum;
    end
  end

  // magnitude and sign
  assign pair_abs = pair[HIST_SUM_W-1] ? -pair : pair;

  always_ff @(posedge clk) begin
    if (adv.mag) begin
      neg_mag  <= pair[HIST_SUM_W-1];
      mag      <= pair_abs[MAG_W-1:0];
      batt_mag <= batt_pair;
    end
  end

  // reciprocal multiply
  always_ff @(posedge clk) begin
    if (adv.mul) begin
      neg_mul  <= neg_mag;
      prod     <= PROD_W'(mag) * PROD_W'(DIV_RECIP);
      batt_mul <= batt_mag;
    end
  end

  // quotient with the sign put back
  assign quot_mag = prod[DIV_SHIFT +: QUOT_W];

  always_ff @(posedge clk) begin
    if (adv.quot) begin
      quot      <= neg_mul ? -$signed({1'b0, quot_mag}) : $signed({1'b0, quot_mag});
      batt_quot <= batt_mul;
    end
  end

  // offset and clamp
  assign total = TOTAL_W'(quot) + TOTAL_W'(batt_quot) + SKIN_OFFSET;

  always_ff @(posedge clk) begin
    if (adv.out) begin
      if (total < SKIN_MIN) begin
        skin_temp <= SKIN_MIN[SKIN_W-1:0];
      end else if (total > SKIN_MAX) begin
        skin_temp <= SKIN_MAX[SKIN_W-1:0];
      end else begin
        skin_temp <= total[SKIN_W-1:0];
      end
    end
  end

endmodule
